### rtl/uart_rb_pkg.sv
// ----------------------------------------------------------------------------
// uart_rb_pkg
// shared types and codes of the serial port receive / transmit ring buffers
// ----------------------------------------------------------------------------
package uart_rb_pkg;

	typedef enum logic [1:0] {
		OP_RX_BYTE   = 2'd0,
		OP_APP_READ  = 2'd1,
		OP_APP_WRITE = 2'd2,
		OP_TX_DONE   = 2'd3
	} op_t;

	localparam logic REG_RX_SIZE = 1'b0;
	localparam logic REG_TX_SIZE = 1'b1;

	localparam logic [8:0] SIZE_RESET = 9'd256;

	typedef struct packed {
		logic read_ok;
		logic write_ok;
		logic tx_valid;
		logic tx_fwd;
	} res_flags_t;

endpackage

### rtl/uart_rb_ring_ram.sv
// ----------------------------------------------------------------------------
// uart_rb_ring_ram
// byte ring storage, one write and one registered read port
// ----------------------------------------------------------------------------
module uart_rb_ring_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/uart_rb_ctrl.sv
// ----------------------------------------------------------------------------
// uart_rb_ctrl
// ring pointers, transmitter state and overflow flag; drives both ring memories
// ----------------------------------------------------------------------------
module uart_rb_ctrl #(
	parameter int RING_DEPTH = 256,
	parameter int PW         = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [1:0]             op,
	input  logic [7:0]             data_in,
	input  logic [8:0]             rx_size,
	input  logic [8:0]             tx_size,
	output logic                   rx_we,
	output logic [PW-1:0]          rx_waddr,
	output logic                   rx_re,
	output logic [PW-1:0]          rx_raddr,
	output logic                   tx_we,
	output logic [PW-1:0]          tx_waddr,
	output logic                   tx_re,
	output logic [PW-1:0]          tx_raddr,
	output logic                   done_s1,
	output uart_rb_pkg::res_flags_t flags_s1,
	output logic [7:0]             byte_s1,
	output logic                   overflow
);

	localparam int SW = $clog2(RING_DEPTH + 1);
	localparam logic [8:0] DEPTH_R = 9'(RING_DEPTH);

	logic [PW-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic [PW-1:0] rx_head_d, rx_tail_d, tx_head_d, tx_tail_d;
	logic          tx_busy_q, tx_busy_d;
	logic          ovf_q, ovf_d;
	logic [SW-1:0] rsz, tsz;
	logic [PW-1:0] nx_rh, nx_th;
	uart_rb_pkg::res_flags_t flags;

	function automatic logic [SW-1:0] used_size(input logic [8:0] r);
		logic [SW-1:0] s;
		if (r < 9'd2) begin
			s = SW'(2);
		end else if (r > DEPTH_R) begin
			s = SW'(RING_DEPTH);
		end else begin
			s = r[SW-1:0];
		end
		return s;
	endfunction

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [SW-1:0] s);
		logic [SW-1:0] inc;
		inc = SW'(p) + SW'(1);
		return (inc >= s) ? '0 : inc[PW-1:0];
	endfunction

	assign rsz   = used_size(rx_size);
	assign tsz   = used_size(tx_size);
	assign nx_rh = adv(rx_head_q, rsz);
	assign nx_th = adv(tx_head_q, tsz);

	assign rx_waddr = rx_head_q;
	assign rx_raddr = rx_tail_q;
	assign tx_waddr = tx_head_q;
	assign tx_raddr = tx_tail_q;

	always_comb begin
		rx_head_d = rx_head_q;
		rx_tail_d = rx_tail_q;
		tx_head_d = tx_head_q;
		tx_tail_d = tx_tail_q;
		tx_busy_d = tx_busy_q;
		ovf_d     = ovf_q;
		rx_we     = 1'b0;
		rx_re     = 1'b0;
		tx_we     = 1'b0;
		tx_re     = 1'b0;
		flags     = '0;
		if (accept) begin
			case (uart_rb_pkg::op_t'(op))
				uart_rb_pkg::OP_RX_BYTE: begin
					rx_we     = 1'b1;
					rx_head_d = nx_rh;
					if (nx_rh == rx_tail_q) begin
						rx_tail_d = adv(rx_tail_q, rsz);
						ovf_d     = 1'b1;
					end
				end
				uart_rb_pkg::OP_APP_READ: begin
					if (rx_tail_q != rx_head_q) begin
						rx_re         = 1'b1;
						flags.read_ok = 1'b1;
						rx_tail_d     = adv(rx_tail_q, rsz);
					end
				end
				uart_rb_pkg::OP_APP_WRITE: begin
					if (nx_th != tx_tail_q) begin
						tx_we          = 1'b1;
						tx_head_d      = nx_th;
						flags.write_ok = 1'b1;
						// empty ring and idle transmitter: byte goes straight out
						if (tx_head_q == tx_tail_q && !tx_busy_q) begin
							flags.tx_valid = 1'b1;
							flags.tx_fwd   = 1'b1;
							tx_tail_d      = adv(tx_tail_q, tsz);
							tx_busy_d      = 1'b1;
						end
					end
				end
				uart_rb_pkg::OP_TX_DONE: begin
					if (tx_head_q != tx_tail_q) begin
						tx_re          = 1'b1;
						flags.tx_valid = 1'b1;
						tx_tail_d      = adv(tx_tail_q, tsz);
						tx_busy_d      = 1'b1;
					end else begin
						tx_busy_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			tx_busy_q <= 1'b0;
			ovf_q     <= 1'b0;
			done_s1   <= 1'b0;
			flags_s1  <= '0;
		end else begin
			rx_head_q <= rx_head_d;
			rx_tail_q <= rx_tail_d;
			tx_head_q <= tx_head_d;
			tx_tail_q <= tx_tail_d;
			tx_busy_q <= tx_busy_d;
			ovf_q     <= ovf_d;
			done_s1   <= accept;
			flags_s1  <= flags;
		end
	end

	always_ff @(posedge clk) begin
		byte_s1 <= data_in;
	end

	assign overflow = ovf_q;

endmodule

### rtl/uart_rx_tx_ring_buffers.sv
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// receive and transmit ring buffers of a serial port, one event per item
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low; busy stays low, so an
// item may be issued in every cycle. op selects the event: byte received,
// application read, application write, transmit complete.
// each item gives one result in the next cycle: done is high for exactly that
// cycle and read_byte, read_ok, write_ok, tx_valid, tx_byte and rx_overflow
// are valid with it. the receiver cannot stall; results are never held.
// all result fields are registered, the read bytes in the registered read
// port of the ring memories; throughput is one item per cycle.
// the ring sizes are set through the apb port (rx at 0, tx at 4) while idle.
// reset clears pointers, transmitter state and overflow flag and sets both
// sizes to the maximum; ring contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers #(
	parameter int RING_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [7:0]  data_in,
	output logic        done,
	output logic [7:0]  read_byte,
	output logic        read_ok,
	output logic        write_ok,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        rx_overflow,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PW = $clog2(RING_DEPTH);

	logic [8:0]    rx_size_q, tx_size_q;
	logic          accept;
	logic          cfg_wr;
	logic          rx_we, rx_re, tx_we, tx_re;
	logic [PW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
	logic [7:0]    rx_rdata, tx_rdata, byte_s1;
	uart_rb_pkg::res_flags_t flags_s1;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_size_q <= uart_rb_pkg::SIZE_RESET;
			tx_size_q <= uart_rb_pkg::SIZE_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == uart_rb_pkg::REG_RX_SIZE) begin
				rx_size_q <= pwdata[8:0];
			end else begin
				tx_size_q <= pwdata[8:0];
			end
		end
	end

	assign prdata = (paddr[2] == uart_rb_pkg::REG_TX_SIZE) ? {23'd0, tx_size_q}
	                                                      : {23'd0, rx_size_q};

	uart_rb_ctrl #(
		.RING_DEPTH(RING_DEPTH),
		.PW        (PW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.op      (op),
		.data_in (data_in),
		.rx_size (rx_size_q),
		.tx_size (tx_size_q),
		.rx_we   (rx_we),
		.rx_waddr(rx_waddr),
		.rx_re   (rx_re),
		.rx_raddr(rx_raddr),
		.tx_we   (tx_we),
		.tx_waddr(tx_waddr),
		.tx_re   (tx_re),
		.tx_raddr(tx_raddr),
		.done_s1 (done),
		.flags_s1(flags_s1),
		.byte_s1 (byte_s1),
		.overflow(rx_overflow)
	);

	uart_rb_ring_ram #(
		.DEPTH(RING_DEPTH),
		.AW   (PW)
	) u_rx_ram (
		.clk  (clk),
		.we   (rx_we),
		.waddr(rx_waddr),
		.wdata(data_in),
		.re   (rx_re),
		.raddr(rx_raddr),
		.rdata(rx_rdata)
	);

	uart_rb_ring_ram #(
		.DEPTH(RING_DEPTH),
		.AW   (PW)
	) u_tx_ram (
		.clk  (clk),
		.we   (tx_we),
		.waddr(tx_waddr),
		.wdata(data_in),
		.re   (tx_re),
		.raddr(tx_raddr),
		.rdata(tx_rdata)
	);

	// result fields; tx_byte is the forwarded byte when a write starts the idle transmitter
	assign read_ok   = flags_s1.read_ok;
	assign write_ok  = flags_s1.write_ok;
	assign tx_valid  = flags_s1.tx_valid;
	assign read_byte = flags_s1.read_ok ? rx_rdata : 8'd0;
	assign tx_byte   = !flags_s1.tx_valid ? 8'd0 : (flags_s1.tx_fwd ? byte_s1 : tx_rdata);

`ifndef ASSERT_OFF
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("item accepted without a result in the next cycle");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without an accepted item");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(rx_overflow))
		else $error("overflow flag cleared");

	a_tx_source: assert property (@(posedge clk) disable iff (!arst_n)
		accept ##1 (done && tx_valid) |-> ($past(op) == uart_rb_pkg::OP_APP_WRITE ||
		$past(op) == uart_rb_pkg::OP_TX_DONE))
		else $error("byte sent on an event that cannot send");
`endif

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the serial port receive / transmit ring buffers item by item
// ----------------------------------------------------------------------------
// each item is predicted when it is accepted, from a copy of both rings, the
// transmitter state and the ring sizes kept here; the one result it causes is
// compared field by field with that prediction. ring sizes are changed over
// the apb port only while no result is due and the ring whose size changes
// has been read out, so no slot that was never written is ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       read_ok;
		logic       write_ok;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_overflow;
	} ring_reply_t;

	localparam int SLOTS = 256;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = uart_rb_pkg::OP_RX_BYTE;
	logic [7:0]  data_in = '0;
	logic        done;
	logic [7:0]  read_byte;
	logic        read_ok;
	logic        write_ok;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        rx_overflow;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	bit   [7:0]  rx_bytes [SLOTS];
	bit   [7:0]  tx_bytes [SLOTS];
	logic [7:0]  rx_fill_ptr = '0;
	logic [7:0]  rx_take_ptr = '0;
	logic [7:0]  tx_fill_ptr = '0;
	logic [7:0]  tx_take_ptr = '0;
	logic        tx_sending = 1'b0;
	logic        overrun_seen = 1'b0;
	logic [8:0]  rx_size_reg = uart_rb_pkg::SIZE_RESET;
	logic [8:0]  tx_size_reg = uart_rb_pkg::SIZE_RESET;

	ring_reply_t ring_replies [$];
	ring_reply_t reply_due;
	int          error_count = 0;
	bit          idle_gaps = 1'b1;

	uart_rx_tx_ring_buffers uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.data_in     (data_in),
		.done        (done),
		.read_byte   (read_byte),
		.read_ok     (read_ok),
		.write_ok    (write_ok),
		.tx_valid    (tx_valid),
		.tx_byte     (tx_byte),
		.rx_overflow (rx_overflow),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int ring_span(logic [8:0] size_reg);
		if (size_reg < 9'd2)
			return 2;
		if (size_reg > SLOTS)
			return SLOTS;
		return size_reg;
	endfunction

	function automatic logic [7:0] step_ptr(logic [7:0] ptr, int span);
		int n;
		n = ptr + 1;
		if (n >= span)
			return 8'd0;
		return n[7:0];
	endfunction

	// updates the ring copies and returns the result the item must give
	function automatic ring_reply_t apply_ring_event(uart_rb_pkg::op_t ev_op,
			logic [7:0] ev_data);
		ring_reply_t r;
		int          rx_span;
		int          tx_span;
		logic [7:0]  nxt;
		logic        kick;
		logic        send;
		r = '0;
		rx_span = ring_span(rx_size_reg);
		tx_span = ring_span(tx_size_reg);
		send = 1'b0;
		case (ev_op)
			uart_rb_pkg::OP_RX_BYTE: begin
				nxt = step_ptr(rx_fill_ptr, rx_span);
				rx_bytes[rx_fill_ptr] = ev_data;
				rx_fill_ptr = nxt;
				if (nxt == rx_take_ptr) begin
					rx_take_ptr = step_ptr(rx_take_ptr, rx_span);
					overrun_seen = 1'b1;
				end
			end
			uart_rb_pkg::OP_APP_READ: begin
				if (rx_take_ptr != rx_fill_ptr) begin
					r.read_byte = rx_bytes[rx_take_ptr];
					r.read_ok = 1'b1;
					rx_take_ptr = step_ptr(rx_take_ptr, rx_span);
				end
			end
			uart_rb_pkg::OP_APP_WRITE: begin
				kick = (tx_fill_ptr == tx_take_ptr) && !tx_sending;
				nxt = step_ptr(tx_fill_ptr, tx_span);
				if (nxt != tx_take_ptr) begin
					tx_bytes[tx_fill_ptr] = ev_data;
					tx_fill_ptr = nxt;
					r.write_ok = 1'b1;
				end
				if (kick && tx_fill_ptr != tx_take_ptr)
					send = 1'b1;
			end
			default: begin
				if (tx_fill_ptr != tx_take_ptr)
					send = 1'b1;
				else
					tx_sending = 1'b0;
			end
		endcase
		if (send) begin
			r.tx_valid = 1'b1;
			r.tx_byte = tx_bytes[tx_take_ptr];
			tx_take_ptr = step_ptr(tx_take_ptr, tx_span);
			tx_sending = 1'b1;
		end
		r.rx_overflow = overrun_seen;
		return r;
	endfunction

	function automatic void check_field(string name, logic [8:0] exp_val, logic [8:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
			error_count++;
		end
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_gaps || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// mode 0 even mix, mode 1 fills both rings, mode 2 empties them
	function automatic uart_rb_pkg::op_t pick_op(int mode);
		int r;
		int w_rx;
		int w_rd;
		int w_wr;
		r = $urandom_range(0, 99);
		case (mode)
			1: begin
				w_rx = 40;
				w_rd = 10;
				w_wr = 40;
			end
			2: begin
				w_rx = 15;
				w_rd = 35;
				w_wr = 15;
			end
			default: begin
				w_rx = 25;
				w_rd = 25;
				w_wr = 25;
			end
		endcase
		if (r < w_rx)
			return uart_rb_pkg::OP_RX_BYTE;
		if (r < w_rx + w_rd)
			return uart_rb_pkg::OP_APP_READ;
		if (r < w_rx + w_rd + w_wr)
			return uart_rb_pkg::OP_APP_WRITE;
		return uart_rb_pkg::OP_TX_DONE;
	endfunction

	task automatic send_item(uart_rb_pkg::op_t ev_op, logic [7:0] ev_data);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= ev_op;
		data_in <= ev_data;
		do
			@(posedge clk);
		while (busy);
		ring_replies.push_back(apply_ring_event(ev_op, ev_data));
	endtask

	task automatic apb_access(logic [2:0] addr, logic wr, logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_size_reg(logic idx, logic [8:0] exp_val);
		logic [31:0] rd;
		apb_access({idx, 2'b00}, 1'b0, '0, rd);
		check_field(idx == uart_rb_pkg::REG_RX_SIZE ? "rx_ring_size" : "tx_ring_size",
			exp_val, rd[8:0]);
	endtask

	task automatic write_size_reg(logic idx, logic [31:0] val);
		logic [31:0] rd;
		apb_access({idx, 2'b00}, 1'b1, val, rd);
		if (idx == uart_rb_pkg::REG_RX_SIZE)
			rx_size_reg = val[8:0];
		else
			tx_size_reg = val[8:0];
		check_size_reg(idx, val[8:0]);
	endtask

	// a ring whose size changes is read out first
	task automatic set_ring_sizes(logic [31:0] rx_val, logic [31:0] tx_val);
		if (rx_val[8:0] != rx_size_reg)
			while (rx_take_ptr != rx_fill_ptr)
				send_item(uart_rb_pkg::OP_APP_READ, $urandom_range(0, 255));
		if (tx_val[8:0] != tx_size_reg)
			while (tx_take_ptr != tx_fill_ptr)
				send_item(uart_rb_pkg::OP_TX_DONE, $urandom_range(0, 255));
		start <= 1'b0;
		while (ring_replies.size() != 0)
			@(posedge clk);
		write_size_reg(uart_rb_pkg::REG_RX_SIZE, rx_val);
		write_size_reg(uart_rb_pkg::REG_TX_SIZE, tx_val);
	endtask

	task automatic test_reset_values();
		check_size_reg(uart_rb_pkg::REG_RX_SIZE, uart_rb_pkg::SIZE_RESET);
		check_size_reg(uart_rb_pkg::REG_TX_SIZE, uart_rb_pkg::SIZE_RESET);
		send_item(uart_rb_pkg::OP_APP_READ, 8'hFF);
		send_item(uart_rb_pkg::OP_TX_DONE, 8'hFF);
	endtask

	task automatic test_rx_path();
		send_item(uart_rb_pkg::OP_RX_BYTE, 8'h00);
		send_item(uart_rb_pkg::OP_RX_BYTE, 8'hFF);
		send_item(uart_rb_pkg::OP_RX_BYTE, 8'hA5);
		repeat (4) send_item(uart_rb_pkg::OP_APP_READ, 8'h00);
	endtask

	task automatic test_tx_path();
		send_item(uart_rb_pkg::OP_APP_WRITE, 8'hFF);
		send_item(uart_rb_pkg::OP_APP_WRITE, 8'h00);
		send_item(uart_rb_pkg::OP_APP_WRITE, 8'h5A);
		repeat (3) send_item(uart_rb_pkg::OP_TX_DONE, 8'h00);
		send_item(uart_rb_pkg::OP_APP_WRITE, 8'h81);
		send_item(uart_rb_pkg::OP_TX_DONE, 8'hFF);
	endtask

	// sizes below the range saturate to two, one byte per ring
	task automatic test_size_limits();
		set_ring_sizes(32'd1, 32'hFFFF_FE00);
		send_item(uart_rb_pkg::OP_RX_BYTE, 8'h11);
		send_item(uart_rb_pkg::OP_RX_BYTE, 8'h22);
		send_item(uart_rb_pkg::OP_RX_BYTE, 8'h33);
		send_item(uart_rb_pkg::OP_APP_READ, 8'h00);
		send_item(uart_rb_pkg::OP_APP_WRITE, 8'h44);
		send_item(uart_rb_pkg::OP_APP_WRITE, 8'h55);
		send_item(uart_rb_pkg::OP_APP_WRITE, 8'h66);
		send_item(uart_rb_pkg::OP_TX_DONE, 8'h00);
		send_item(uart_rb_pkg::OP_TX_DONE, 8'h00);
	endtask

	task automatic test_full_depth();
		set_ring_sizes(32'd256, 32'd256);
		idle_gaps = 1'b0;
		for (int i = 0; i < 257; i++) begin
			if (i == 128)
				idle_gaps = 1'b1;
			send_item(uart_rb_pkg::OP_RX_BYTE, $urandom_range(0, 255));
		end
		repeat (3) send_item(uart_rb_pkg::OP_APP_READ, $urandom_range(0, 255));
		for (int i = 0; i < 257; i++)
			send_item(uart_rb_pkg::OP_APP_WRITE, $urandom_range(0, 255));
		repeat (3) send_item(uart_rb_pkg::OP_TX_DONE, $urandom_range(0, 255));
	endtask

	task automatic test_random_traffic();
		logic [31:0] rs;
		logic [31:0] ts;
		int          mode;
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin
					rs = 256;
					ts = 256;
				end
				1: begin
					rs = 4;
					ts = 3;
				end
				2: begin
					rs = 2;
					ts = 2;
				end
				3: begin
					rs = 0;
					ts = 1;
				end
				4: begin
					rs = 256;
					ts = 256;
				end
				5: begin
					rs = 511;
					ts = 300;
				end
				8: begin
					rs = $urandom_range(2, 256);
					ts = $urandom_range(2, 256);
				end
				default: begin
					rs = $urandom_range(2, 12);
					ts = $urandom_range(2, 12);
				end
			endcase
			set_ring_sizes(rs, ts);
			mode = 0;
			for (int i = 0; i < 25; i++) begin
				if (i % 15 == 0) begin
					mode = $urandom_range(0, 2);
					idle_gaps = $urandom_range(0, 3) != 0;
				end
				send_item(pick_op(mode), $urandom_range(0, 255));
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (ring_replies.size() == 0) begin
				$display("%0t: result with no item outstanding", $time);
				error_count++;
			end else begin
				reply_due = ring_replies.pop_front();
				check_field("read_byte", 9'(reply_due.read_byte), 9'(read_byte));
				check_field("read_ok", 9'(reply_due.read_ok), 9'(read_ok));
				check_field("write_ok", 9'(reply_due.write_ok), 9'(write_ok));
				check_field("tx_valid", 9'(reply_due.tx_valid), 9'(tx_valid));
				check_field("tx_byte", 9'(reply_due.tx_byte), 9'(tx_byte));
				check_field("rx_overflow", 9'(reply_due.rx_overflow), 9'(rx_overflow));
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_rx_path();
		test_tx_path();
		test_size_limits();
		test_random_traffic();
		test_full_depth();
		start <= 1'b0;
		while (ring_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("uart_rx_tx_ring_buffers verification clean");
		else
			$display("uart_rx_tx_ring_buffers verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("uart_rx_tx_ring_buffers verification failed");
		$finish;
	end

endmodule
